// ===== rtl/pfenc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Playfair digraph encryption core.
// Holds payload structs, square layout constants and letter codes; no dependencies.
package pfenc_pkg;

    localparam int SIDE      = 5;
    localparam int ENTRIES   = SIDE * SIDE;
    localparam int CODE_W    = 5;
    localparam int POS_W     = 3;
    localparam int CFG_W     = 50;
    localparam int CFG_IDX_W = 2;
    localparam int LOW_N     = 10;
    localparam int MID_N     = 10;
    localparam int HIGH_N    = 5;
    localparam int HIGH_W    = HIGH_N * CODE_W;

    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;
    localparam logic [CODE_W-1:0] CODE_X = 5'd23;

    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_HIGH = 2'd2;

    localparam logic [CFG_W-1:0]  SQUARE_LOW_RST  = 50'd71472062881930;
    localparam logic [CFG_W-1:0]  SQUARE_MID_RST  = 50'd651440652819653;
    localparam logic [HIGH_W-1:0] SQUARE_HIGH_RST = 25'd26990227;

    typedef logic [ENTRIES-1:0][CODE_W-1:0] square_t;

    typedef struct packed {
        logic [CODE_W-1:0] letter;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] cipher_letter;
        logic              pair_last;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

endpackage

// ===== rtl/playfair_digraph_encrypt_core.sv =====
`timescale 1ns / 1ps
// Playfair digraph encryption core: pairing, lookup, substitution and output buffer.
// Depends on pfenc_pkg.
//
// Takes one plaintext letter per cycle while in_ready is high; returns ciphertext one
// letter per transfer. A letter that opens a pair is held; the letter that closes it
// (or an end-of-text letter with nothing held, padded with X) moves the pair into a pair
// register. Parallel square compares and corner/neighbor selection on it give two
// cipher letters in the result register, which delivers them over two transfers.
// Sustained rate is one letter per cycle while out_ready is high; the result register,
// sending two letters per pair, is what limits it when pairs are padded by end of text.
// The user must write the key square through the configuration port only while the
// core is idle; the core itself does not enforce it.
module playfair_digraph_encrypt_core
    import pfenc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Locate a code in the square; lowest entry wins, no match gives entry 0.
    function automatic pos_t find_pos(input square_t sq, input logic [CODE_W-1:0] code);
        pos_t p;
        p = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r * SIDE + c] == code) begin
                    p.row = POS_W'(r);
                    p.col = POS_W'(c);
                end
            end
        end
        return p;
    endfunction

    // Read the square entry at a row and column.
    function automatic logic [CODE_W-1:0] read_sq(input square_t sq, input pos_t p);
        logic [CODE_W-1:0] v;
        v = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (p.row == POS_W'(r) && p.col == POS_W'(c)) begin
                    v = sq[r * SIDE + c];
                end
            end
        end
        return v;
    endfunction

    function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] v);
        return (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
    endfunction

    logic [CFG_W-1:0]  sq_low_reg;
    logic [CFG_W-1:0]  sq_mid_reg;
    logic [HIGH_W-1:0] sq_high_reg;
    square_t           square;

    logic              holding_reg, holding_next;
    logic [CODE_W-1:0] held_reg, held_next;

    logic              pair_valid_reg, pair_valid_next;
    logic [CODE_W-1:0] pair_a_reg, pair_a_next;
    logic [CODE_W-1:0] pair_b_reg, pair_b_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_second_reg, out_second_next;
    logic [CODE_W-1:0] out_a_reg, out_a_next;
    logic [CODE_W-1:0] out_b_reg, out_b_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              out_free;
    logic              pair_move;
    logic              pair_free;
    logic              forms_pair;
    logic [CODE_W-1:0] norm_letter;
    pos_t              pos_a, pos_b, enc_a, enc_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sq_low_reg  <= SQUARE_LOW_RST;
            sq_mid_reg  <= SQUARE_MID_RST;
            sq_high_reg <= SQUARE_HIGH_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SQUARE_LOW:  sq_low_reg  <= cfg_data;
                REG_SQUARE_MID:  sq_mid_reg  <= cfg_data;
                REG_SQUARE_HIGH: sq_high_reg <= cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the square into entries, row-major
    always_comb begin
        for (int k = 0; k < LOW_N; k++) begin
            square[k] = sq_low_reg[k * CODE_W +: CODE_W];
        end
        for (int k = 0; k < MID_N; k++) begin
            square[LOW_N + k] = sq_mid_reg[k * CODE_W +: CODE_W];
        end
        for (int k = 0; k < HIGH_N; k++) begin
            square[LOW_N + MID_N + k] = sq_high_reg[k * CODE_W +: CODE_W];
        end
    end

    // Handshake and stage flow
    assign norm_letter = (in_item.letter == CODE_J) ? CODE_I : in_item.letter;
    assign out_xfer    = out_valid_reg && out_ready;
    assign out_free    = !out_valid_reg || (out_xfer && out_second_reg);
    assign pair_move   = pair_valid_reg && out_free;
    assign pair_free   = !pair_valid_reg || pair_move;
    assign forms_pair  = holding_reg || in_item.end_of_text;
    assign in_ready    = pair_free || !forms_pair;
    assign in_xfer     = in_valid && in_ready;

    // Encrypt the pair register
    always_comb begin
        pos_a = find_pos(square, pair_a_reg);
        pos_b = find_pos(square, pair_b_reg);
        if (pos_a.row == pos_b.row) begin
            enc_a.row = pos_a.row;
            enc_a.col = wrap_inc(pos_a.col);
            enc_b.row = pos_b.row;
            enc_b.col = wrap_inc(pos_b.col);
        end else if (pos_a.col == pos_b.col) begin
            enc_a.row = wrap_inc(pos_a.row);
            enc_a.col = pos_a.col;
            enc_b.row = wrap_inc(pos_b.row);
            enc_b.col = pos_b.col;
        end else begin
            enc_a.row = pos_a.row;
            enc_a.col = pos_b.col;
            enc_b.row = pos_b.row;
            enc_b.col = pos_a.col;
        end
    end

    // Next state: hold first letters, form pairs, advance results
    always_comb begin
        holding_next    = holding_reg;
        held_next       = held_reg;
        pair_valid_next = pair_valid_reg;
        pair_a_next     = pair_a_reg;
        pair_b_next     = pair_b_reg;
        out_valid_next  = out_valid_reg;
        out_second_next = out_second_reg;
        out_a_next      = out_a_reg;
        out_b_next      = out_b_reg;

        // Advance within the result register
        if (out_xfer) begin
            if (out_second_reg) begin
                out_valid_next  = 1'b0;
                out_second_next = 1'b0;
            end else begin
                out_second_next = 1'b1;
            end
        end

        // Move the pair into the result register
        if (pair_move) begin
            out_valid_next  = 1'b1;
            out_second_next = 1'b0;
            out_a_next      = read_sq(square, enc_a);
            out_b_next      = read_sq(square, enc_b);
            pair_valid_next = 1'b0;
        end

        // Take the input letter
        if (in_xfer) begin
            if (holding_reg) begin
                pair_valid_next = 1'b1;
                pair_a_next     = held_reg;
                pair_b_next     = norm_letter;
                holding_next    = 1'b0;
                held_next       = '0;
            end else if (in_item.end_of_text) begin
                pair_valid_next = 1'b1;
                pair_a_next     = norm_letter;
                pair_b_next     = CODE_X;
            end else begin
                holding_next = 1'b1;
                held_next    = norm_letter;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            holding_reg    <= 1'b0;
            held_reg       <= '0;
            pair_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_second_reg <= 1'b0;
        end else begin
            holding_reg    <= holding_next;
            held_reg       <= held_next;
            pair_valid_reg <= pair_valid_next;
            out_valid_reg  <= out_valid_next;
            out_second_reg <= out_second_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        pair_a_reg <= pair_a_next;
        pair_b_reg <= pair_b_next;
        out_a_reg  <= out_a_next;
        out_b_reg  <= out_b_next;
    end

    // Drive the result port
    assign out_valid              = out_valid_reg;
    assign out_item.cipher_letter = out_second_reg ? out_b_reg : out_a_reg;
    assign out_item.pair_last     = out_second_reg;

endmodule
